// ===== rtl/paged_mono_bitmap_blitter_core_defines.svh =====
`ifndef PAGED_MONO_BITMAP_BLITTER_CORE_DEFINES_SVH
`define PAGED_MONO_BITMAP_BLITTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PMBB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PMBB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pmbb_pkg.sv =====
package pmbb_pkg;

  localparam int SCREEN_COLS = 128;
  localparam int SCREEN_ROWS = 64;
  localparam int PAGE_COUNT  = SCREEN_ROWS / 8;
  localparam int STORE_SIZE  = SCREEN_COLS * PAGE_COUNT;
  localparam int ADDR_W      = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int PG_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int COL_W       = $clog2(SCREEN_COLS);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;

  typedef enum logic [1:0] {
    FUNC_BLIT  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DRAW_SET   = 2'd0,
    DRAW_CLEAR = 2'd1,
    DRAW_XOR   = 2'd2
  } draw_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST_X        = 3'd0,
    CFG_DEST_Y        = 3'd1,
    CFG_BITMAP_WIDTH  = 3'd2,
    CFG_BITMAP_HEIGHT = 3'd3,
    CFG_DRAW_MODE     = 3'd4,
    CFG_MIRROR_X      = 3'd5,
    CFG_MIRROR_Y      = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PLAN,
    S_ACC0,
    S_ACC1,
    S_ACC2,
    S_HOLD
  } state_t;

  typedef struct packed {
    func_t      func;
    logic [4:0] page;
    logic [7:0] column;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] bytes_written;
  } out_item_t;

  typedef struct packed {
    logic [8:0] dest_x;
    logic [8:0] dest_y;
    logic [7:0] bitmap_width;
    logic [7:0] bitmap_height;
    draw_mode_t draw_mode;
    logic       mirror_x;
    logic       mirror_y;
  } cfg_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              rmw0;
    logic              rmw1;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [7:0]        bits0;
    logic [7:0]        bits1;
    logic [1:0]        nwr;
  } plan_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/pmbb_cfg.sv =====
module pmbb_cfg import pmbb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_x        <= '0;
      cfg.dest_y        <= '0;
      cfg.bitmap_width  <= 8'd8;
      cfg.bitmap_height <= 8'd8;
      cfg.draw_mode     <= DRAW_SET;
      cfg.mirror_x      <= 1'b0;
      cfg.mirror_y      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEST_X:        cfg.dest_x        <= cfg_data;
        CFG_DEST_Y:        cfg.dest_y        <= cfg_data;
        CFG_BITMAP_WIDTH:  cfg.bitmap_width  <= cfg_data[7:0];
        CFG_BITMAP_HEIGHT: cfg.bitmap_height <= cfg_data[7:0];
        CFG_DRAW_MODE:     cfg.draw_mode     <= draw_mode_t'(cfg_data[1:0]);
        CFG_MIRROR_X:      cfg.mirror_x      <= cfg_data[0];
        CFG_MIRROR_Y:      cfg.mirror_y      <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pmbb_plan.sv =====
module pmbb_plan import pmbb_pkg::*; (
  input  logic     clk,
  input  logic     item_load,
  input  in_item_t item,
  input  logic     plan_load,
  input  cfg_t     cfg,
  output plan_t    plan
);

  localparam int GW = 11;
  localparam logic signed [GW-1:0] COL_MAX  = GW'(SCREEN_COLS - 1);
  localparam logic signed [GW-1:0] ROW_MAX  = GW'(SCREEN_ROWS - 1);
  localparam logic signed [GW-1:0] PAGE_MAX = GW'(PAGE_COUNT - 1);

  function automatic logic [3:0] eight_mod(input logic [7:0] h);
    logic [3:0] r;
    case (h) inside
      8'd0, 8'd1, 8'd2, 8'd4, 8'd8: r = 4'd0;
      8'd3, 8'd6:                   r = 4'd2;
      8'd5:                         r = 4'd3;
      8'd7:                         r = 4'd1;
      default:                      r = 4'd8;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] flip_bits(input logic [7:0] v);
    logic [7:0] t;
    t = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
    t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
    t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
    return t;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [PG_W-1:0] pg,
                                                input logic [COL_W-1:0] col);
    return ADDR_W'(pg) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
  endfunction

  in_item_t              item_q;
  plan_t                 plan_next;
  logic signed [GW-1:0]  xs, ys, xw, yh, neg, srow, brow, brow1, icol, sx;
  logic [3:0]            ymod, off;
  logic [5:0]            rows;
  logic                  geo_ok, blit_ok, raw_ok, is_blit;
  logic [7:0]            b;
  logic [15:0]           wide;
  logic [PG_W-1:0]       pg0, pg1;
  logic [COL_W-1:0]      colb;

  always_comb begin
    is_blit = item_q.func == FUNC_BLIT;
    ymod    = cfg.mirror_y ? eight_mod(cfg.bitmap_height) : 4'd0;
    xs      = GW'($signed(cfg.dest_x));
    ys      = GW'($signed(cfg.dest_y)) - $signed({7'b0, ymod});
    xw      = xs + $signed({3'b0, cfg.bitmap_width});
    yh      = ys + $signed({3'b0, cfg.bitmap_height});
    geo_ok  = cfg.bitmap_width != 8'd0 && cfg.bitmap_height != 8'd0 &&
              xw > 0 && xs <= COL_MAX && yh > 0 && ys <= ROW_MAX;
    rows    = 6'(({1'b0, cfg.bitmap_height} + 9'd7) >> 3);

    // negative y: page rounds down (one page further for a multiple of 8), offset runs 1..8
    neg = -ys;
    if (ys < 0) begin
      off  = 4'd8 - {1'b0, neg[2:0]};
      srow = ~(neg >>> 3);
    end else begin
      off  = {1'b0, ys[2:0]};
      srow = ys >>> 3;
    end
    brow  = srow + $signed({6'b0, item_q.page});
    brow1 = brow + 11'sd1;

    icol = cfg.mirror_x ?
           $signed({3'b0, cfg.bitmap_width}) - 11'sd1 - $signed({3'b0, item_q.column}) :
           $signed({3'b0, item_q.column});
    sx   = xs + icol;

    blit_ok = is_blit && geo_ok && {1'b0, item_q.page} < rows &&
              item_q.column < cfg.bitmap_width &&
              brow <= PAGE_MAX && brow > -2 && sx >= 0 && sx <= COL_MAX;

    b    = cfg.mirror_y ? flip_bits(item_q.data_byte) : item_q.data_byte;
    wide = {8'b0, b} << off;

    raw_ok = {1'b0, item_q.page} < 6'(PAGE_COUNT) &&
             {1'b0, item_q.column} < 9'(SCREEN_COLS);

    pg0  = brow[PG_W-1:0];
    pg1  = brow1[PG_W-1:0];
    colb = sx[COL_W-1:0];

    plan_next.rmw0  = blit_ok && brow >= 0;
    plan_next.rmw1  = blit_ok && off != 4'd0 && brow < PAGE_MAX;
    plan_next.rd    = item_q.func == FUNC_READ && raw_ok;
    plan_next.wr    = item_q.func == FUNC_WRITE && raw_ok;
    plan_next.addr0 = is_blit ? addr_of(pg0, colb) :
                      addr_of(item_q.page[PG_W-1:0], item_q.column[COL_W-1:0]);
    plan_next.addr1 = addr_of(pg1, colb);
    plan_next.bits0 = is_blit ? wide[7:0] : item_q.data_byte;
    plan_next.bits1 = wide[15:8];
    plan_next.nwr   = {1'b0, plan_next.rmw0} + {1'b0, plan_next.rmw1} +
                      {1'b0, plan_next.wr};
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      item_q <= item;
    end
    if (plan_load) begin
      plan <= plan_next;
    end
  end

endmodule

// ===== rtl/pmbb_store.sv =====
module pmbb_store import pmbb_pkg::*; (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0] mem [STORE_SIZE];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/paged_mono_bitmap_blitter_core.sv =====
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data   (in_item_t)
// out      output     out_valid / out_ready  out_data  (out_item_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request passes through accept, plan, then read, modify-write and second
// modify-write on the framebuffer memory (one write port, one read port).
// Result is registered when the request finishes; the next request is accepted only after that.
// After reset a clearing pass zeroes all STORE_SIZE (1024) entries of the store;
// in_ready stays low meanwhile, cfg writes are always taken.
// A waiting result does not block accept; a finished request holds until out is free.
`include "paged_mono_bitmap_blitter_core_defines.svh"

module paged_mono_bitmap_blitter_core import pmbb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_SIZE - 1);

  function automatic logic [7:0] merge_byte(input logic [7:0] cur,
                                            input logic [7:0] bits,
                                            input draw_mode_t mode);
    logic [7:0] r;
    unique case (mode)
      DRAW_SET:   r = cur | bits;
      DRAW_CLEAR: r = cur & ~bits;
      default:    r = cur ^ bits;
    endcase
    return r;
  endfunction

  cfg_t              cfg;
  plan_t             plan;
  mem_req_t          mem_req;
  logic [7:0]        mem_rdata;
  state_t            state, state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [7:0]        rd_hold;
  logic              item_load, plan_load, done;

  assign cfg_ready = 1'b1;

  pmbb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pmbb_plan u_plan (
    .clk       (clk),
    .item_load (item_load),
    .item      (in_data),
    .plan_load (plan_load),
    .cfg       (cfg),
    .plan      (plan)
  );

  pmbb_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    item_load  = 1'b0;
    plan_load  = 1'b0;
    done       = 1'b0;
    mem_req    = '0;
    unique case (state)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr;
        mem_req.wdata = 8'd0;
        if (clr_addr == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_load  = 1'b1;
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        plan_load  = 1'b1;
        state_next = S_ACC0;
      end
      S_ACC0: begin
        mem_req.we    = plan.wr;
        mem_req.waddr = plan.addr0;
        mem_req.wdata = plan.bits0;
        mem_req.re    = plan.rd | plan.rmw0;
        mem_req.raddr = plan.addr0;
        state_next    = S_ACC1;
      end
      S_ACC1: begin
        mem_req.we    = plan.rmw0;
        mem_req.waddr = plan.addr0;
        mem_req.wdata = merge_byte(mem_rdata, plan.bits0, cfg.draw_mode);
        mem_req.re    = plan.rmw1;
        mem_req.raddr = plan.addr1;
        state_next    = S_ACC2;
      end
      S_ACC2: begin
        mem_req.we    = plan.rmw1;
        mem_req.waddr = plan.addr1;
        mem_req.wdata = merge_byte(mem_rdata, plan.bits1, cfg.draw_mode);
        if (!out_valid || out_ready) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid || out_ready) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ACC1) begin
      rd_hold <= plan.rd ? mem_rdata : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data.read_data     <= rd_hold;
      out_data.bytes_written <= plan.nwr;
    end
  end

  `PMBB_ASSERT_IMP(a_idle_no_write, state == S_IDLE, !mem_req.we, "store written while idle")
  `PMBB_ASSERT_NXT(a_accept_plans, in_valid && in_ready, state == S_PLAN, "request not planned")
  `PMBB_ASSERT_IMP(a_pages_differ, state == S_ACC1 && plan.rmw0 && plan.rmw1,
                   plan.addr0 != plan.addr1, "both merges hit one entry")
  `PMBB_ASSERT_IMP(a_count_range, out_valid, out_data.bytes_written != 2'd3,
                   "byte count out of range")

endmodule

// ===== verif/paged_mono_bitmap_blitter_core_tb.sv =====
module paged_mono_bitmap_blitter_core_tb import pmbb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_REQUESTS = 1450;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int LONG_HOLD       = 200;
  localparam int TAIL_CYCLES     = 20;
  localparam int MAX_PRINTS      = 20;
  // mode three behaves as xor
  localparam logic [1:0]           DRAW_MODE_THREE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE       = 3'd7;

  typedef struct packed {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              req;
    bit                    fixed;
    out_item_t             want;
  } step_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  cfg_t       regs_model;
  logic [7:0] frame_model [STORE_SIZE];
  out_item_t  pending_results [$];
  step_t      directed_steps [$];
  int         mismatches      = 0;
  int         results_checked = 0;
  int         requests_sent   = 0;
  int         hold_token      = 0;
  int         burst_left      = 0;
  bit         no_gaps         = 1'b0;
  int         idle_cycles     = 0;

  paged_mono_bitmap_blitter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_model();
    regs_model               = '0;
    regs_model.bitmap_width  = 8'd8;
    regs_model.bitmap_height = 8'd8;
    regs_model.draw_mode     = DRAW_SET;
    foreach (frame_model[i]) frame_model[i] = 8'h00;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_DEST_X:        regs_model.dest_x        = val;
      CFG_DEST_Y:        regs_model.dest_y        = val;
      CFG_BITMAP_WIDTH:  regs_model.bitmap_width  = val[7:0];
      CFG_BITMAP_HEIGHT: regs_model.bitmap_height = val[7:0];
      CFG_DRAW_MODE:     regs_model.draw_mode     = draw_mode_t'(val[1:0]);
      CFG_MIRROR_X:      regs_model.mirror_x      = val[0];
      CFG_MIRROR_Y:      regs_model.mirror_y      = val[0];
      default: ;
    endcase
  endfunction

  function automatic void merge_byte(int pg, int col, logic [7:0] bits);
    int addr;
    addr = pg * SCREEN_COLS + col;
    case (regs_model.draw_mode)
      DRAW_SET:   frame_model[addr] = frame_model[addr] | bits;
      DRAW_CLEAR: frame_model[addr] = frame_model[addr] & ~bits;
      default:    frame_model[addr] = frame_model[addr] ^ bits;
    endcase
  endfunction

  function automatic logic [1:0] blit_count(logic [4:0] band, logic [7:0] column,
                                            logic [7:0] data);
    int         w, h, x, y, rows, off, srow, brow, icol, sx;
    logic [7:0] b;
    logic [1:0] n;
    w = int'(regs_model.bitmap_width);
    h = int'(regs_model.bitmap_height);
    x = $signed(regs_model.dest_x);
    y = $signed(regs_model.dest_y);
    n = 2'd0;
    if (w == 0 || h == 0) return 2'd0;
    if (regs_model.mirror_y) y = y - (8 % h);
    if (x + w <= 0 || x > SCREEN_COLS - 1 || y + h <= 0 || y > SCREEN_ROWS - 1)
      return 2'd0;
    rows = h / 8 + ((h % 8) != 0);
    if (int'(band) >= rows || int'(column) >= w) return 2'd0;
    off  = (y < 0 ? -y : y) % 8;
    srow = y / 8;
    // negative rows: page below, complement offset (multiple of 8 gives 8)
    if (y < 0) begin
      srow = srow - 1;
      off  = 8 - off;
    end
    brow = srow + int'(band);
    if (brow > PAGE_COUNT - 1 || brow <= -2) return 2'd0;
    icol = regs_model.mirror_x ? (w - 1 - int'(column)) : int'(column);
    sx   = x + icol;
    if (sx > SCREEN_COLS - 1 || sx < 0) return 2'd0;
    b = data;
    if (regs_model.mirror_y) begin
      for (int i = 0; i < 8; i++) b[i] = data[7 - i];
    end
    if (brow >= 0) begin
      merge_byte(brow, sx, 8'((16'(b) << off)));
      n++;
    end
    if (off != 0 && brow < PAGE_COUNT - 1) begin
      merge_byte(brow + 1, sx, b >> (8 - off));
      n++;
    end
    return n;
  endfunction

  function automatic out_item_t predict_result(in_item_t req);
    out_item_t res;
    bit        on_screen;
    int        addr;
    res       = '0;
    on_screen = int'(req.page) < PAGE_COUNT && int'(req.column) < SCREEN_COLS;
    addr      = int'(req.page) * SCREEN_COLS + int'(req.column);
    case (req.func)
      FUNC_BLIT: res.bytes_written = blit_count(req.page, req.column, req.data_byte);
      FUNC_READ: if (on_screen) res.read_data = frame_model[addr];
      FUNC_WRITE: if (on_screen) begin
        frame_model[addr] = req.data_byte;
        res.bytes_written = 2'd1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_req(func_t f, int pg, int col, int data = 0,
                                  bit fixed = 1'b0, int rd = 0, int nb = 0);
    step_t s;
    s                    = '0;
    s.req.func           = f;
    s.req.page           = 5'(pg);
    s.req.column         = 8'(col);
    s.req.data_byte      = 8'(data);
    s.fixed              = fixed;
    s.want.read_data     = 8'(rd);
    s.want.bytes_written = 2'(nb);
    directed_steps.push_back(s);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, int val);
    step_t s;
    s         = '0;
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = 9'(val);
    directed_steps.push_back(s);
  endfunction

  function automatic void build_directed();
    add_req(FUNC_READ, 0, 0, 0, 1, 0, 0);
    add_req(FUNC_READ, 7, 127, 0, 1, 0, 0);
    add_req(FUNC_WRITE, 0, 0, 'hA5, 1, 0, 1);
    add_req(FUNC_READ, 0, 0, 0, 1, 'hA5, 0);
    add_req(FUNC_WRITE, 7, 127, 'hFF, 1, 0, 1);
    add_req(FUNC_READ, 8, 0, 0, 1, 0, 0);
    add_req(FUNC_READ, 31, 255, 0, 1, 0, 0);
    add_req(FUNC_WRITE, 0, 128, 'hFF, 1, 0, 0);
    add_req(FUNC_NOP, 3, 3, 'h55, 1, 0, 0);
    add_req(FUNC_BLIT, 0, 0, 'h5A, 1, 0, 1);
    add_req(FUNC_BLIT, 1, 0, 'hFF, 1, 0, 0);
    add_req(FUNC_BLIT, 0, 8, 'hFF, 1, 0, 0);
    add_req(FUNC_READ, 0, 0);
    // straddles two pages
    add_reg(CFG_DEST_Y, 3);
    add_reg(CFG_DRAW_MODE, DRAW_XOR);
    add_req(FUNC_BLIT, 0, 7, 'hFF, 1, 0, 2);
    add_req(FUNC_READ, 1, 7);
    // negative multiple of 8: offset 8, start two pages up
    add_reg(CFG_DEST_Y, -8);
    add_reg(CFG_BITMAP_HEIGHT, 16);
    add_reg(CFG_DRAW_MODE, DRAW_MODE_THREE);
    add_req(FUNC_BLIT, 0, 0, 'hFF, 1, 0, 0);
    add_req(FUNC_BLIT, 1, 2, 'h01);
    add_req(FUNC_READ, 0, 2);
    // both mirrors, right edge clip
    add_reg(CFG_DEST_X, 126);
    add_reg(CFG_DEST_Y, 0);
    add_reg(CFG_BITMAP_HEIGHT, 5);
    add_reg(CFG_MIRROR_X, 1);
    add_reg(CFG_MIRROR_Y, 1);
    add_req(FUNC_BLIT, 0, 0, 'hFF);
    add_req(FUNC_BLIT, 0, 7, 'hC3);
    add_req(FUNC_READ, 0, 126);
    add_reg(CFG_DEST_X, -256);
    add_reg(CFG_DEST_Y, 255);
    add_reg(CFG_BITMAP_WIDTH, 255);
    add_reg(CFG_BITMAP_HEIGHT, 255);
    add_reg(CFG_MIRROR_X, 0);
    add_reg(CFG_MIRROR_Y, 0);
    add_req(FUNC_BLIT, 5, 200, 'hFF, 1, 0, 0);
    add_reg(CFG_DEST_X, 0);
    add_reg(CFG_DEST_Y, 0);
    add_reg(CFG_BITMAP_WIDTH, 0);
    add_req(FUNC_BLIT, 0, 0, 'hFF, 1, 0, 0);
    // bottom page, high part clipped
    add_reg(CFG_DEST_X, 120);
    add_reg(CFG_DEST_Y, 60);
    add_reg(CFG_BITMAP_WIDTH, 8);
    add_reg(CFG_BITMAP_HEIGHT, 8);
    add_reg(CFG_DRAW_MODE, DRAW_CLEAR);
    add_req(FUNC_BLIT, 0, 0, 'hFF);
    add_req(FUNC_READ, 7, 120);
  endfunction

  function automatic in_item_t make_request();
    in_item_t req;
    int       w, rows, kind, col;
    w              = int'(regs_model.bitmap_width);
    rows           = (int'(regs_model.bitmap_height) + 7) / 8;
    req.data_byte  = 8'($urandom);
    kind           = $urandom_range(0, 99);
    if (kind < 55) begin
      req.func   = FUNC_BLIT;
      req.page   = (rows == 0 || $urandom_range(0, 9) == 0) ? 5'($urandom)
                                                            : 5'($urandom_range(0, rows - 1));
      req.column = (w == 0 || $urandom_range(0, 9) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, w - 1));
    end else if (kind < 85) begin
      req.func = (kind < 72) ? FUNC_READ : FUNC_WRITE;
      req.page = 5'($urandom_range(0, PAGE_COUNT - 1));
      col      = $signed(regs_model.dest_x) + int'($urandom_range(0, w));
      if ($urandom_range(0, 1) == 0 || col < 0 || col > SCREEN_COLS - 1)
        col = $urandom_range(0, SCREEN_COLS - 1);
      req.column = 8'(col);
    end else begin
      req.func   = func_t'(2'($urandom_range(0, 3)));
      req.page   = 5'($urandom);
      req.column = 8'($urandom);
    end
    return req;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("%0t: %s", $time, what);
  endtask

  task automatic send_request(in_item_t req, bit fixed, out_item_t want);
    int        gap;
    out_item_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    res = predict_result(req);
    pending_results.push_back(fixed ? want : res);
    if (req.func != FUNC_NOP) requests_sent++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    burst_left = 0;
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  task automatic new_setup(bit every_reg);
    int                    v;
    logic [CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'd0;
    if (every_reg || $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0:       v = -256;
        1:       v = 255;
        2:       v = SCREEN_COLS - 1;
        3:       v = int'($urandom_range(0, 511)) - 256;
        default: v = int'($urandom_range(0, 160)) - 24;
      endcase
      set_reg(CFG_DEST_X, 9'(v));
    end
    if (every_reg || $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0:       v = -256;
        1:       v = 255;
        2:       v = SCREEN_ROWS - 1;
        3:       v = int'($urandom_range(0, 511)) - 256;
        4:       v = -8 * int'($urandom_range(1, 4));
        5:       v = -int'($urandom_range(1, 7));
        default: v = int'($urandom_range(0, 88)) - 16;
      endcase
      set_reg(CFG_DEST_Y, 9'(v));
    end
    if (every_reg || $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0:       v = 0;
        1:       v = 255;
        2:       v = $urandom_range(0, 255);
        default: v = $urandom_range(1, 24);
      endcase
      set_reg(CFG_BITMAP_WIDTH, {junk[8], v[7:0]});
    end
    if (every_reg || $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0:       v = 0;
        1:       v = 255;
        2:       v = $urandom_range(0, 255);
        default: v = $urandom_range(1, 24);
      endcase
      set_reg(CFG_BITMAP_HEIGHT, {junk[8], v[7:0]});
    end
    if (every_reg || $urandom_range(0, 1) == 0) begin
      v = $urandom_range(0, 3);
      set_reg(CFG_DRAW_MODE, {junk[8:2], v[1:0]});
    end
    if (every_reg || $urandom_range(0, 1) == 0) begin
      v = $urandom_range(0, 1);
      set_reg(CFG_MIRROR_X, {junk[8:1], v[0]});
    end
    if (every_reg || $urandom_range(0, 1) == 0) begin
      v = $urandom_range(0, 1);
      set_reg(CFG_MIRROR_Y, {junk[8:1], v[0]});
    end
    if ($urandom_range(0, 7) == 0) set_reg(CFG_SPARE, 9'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // receiver: stall pattern changes every so often; long hold on request
  initial begin : receiver
    int mode, left, seen;
    mode = 0;
    left = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (hold_token != seen) begin
        seen = hold_token;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 120);
      end
      left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 0);
        2:       out_ready <= ($urandom_range(0, 4) == 0);
        default: out_ready <= ($urandom_range(0, 5) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_checked));
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_data !== want.read_data)
          report_mismatch($sformatf("result %0d read_data %02h, expected %02h",
                                    results_checked, out_data.read_data, want.read_data));
        if (out_data.bytes_written !== want.bytes_written)
          report_mismatch($sformatf("result %0d bytes_written %0d, expected %0d",
                                    results_checked, out_data.bytes_written,
                                    want.bytes_written));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : stimulus
    step_t row;
    int    phase;
    int    len;
    reset_model();
    build_directed();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.is_reg) begin
        wait_all_results();
        set_reg(row.reg_idx, row.reg_val);
        cfg_valid <= 1'b0;
      end else begin
        send_request(row.req, row.fixed, row.want);
      end
    end
    phase = 0;
    while (requests_sent < TARGET_REQUESTS) begin
      wait_all_results();
      new_setup(phase % 8 == 0);
      // back-pressure phase: receiver holds off while requests keep coming
      no_gaps = (phase % 11 == 5);
      if (no_gaps) hold_token <= hold_token + 1;
      len = $urandom_range(15, 60);
      repeat (len) begin
        if ($urandom_range(0, 49) == 0) wait_all_results();
        send_request(make_request(), 1'b0, '0);
      end
      phase++;
    end
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
